>>> hw/rtl/vntc_pkg.sv
// Shared constants and types for the value noise tile classifier.
`default_nettype none

package vntc_pkg;

  // Configuration register indexes.
  localparam logic [7:0] REG_NOISE_SEED       = 8'd0;
  localparam logic [7:0] REG_SAMPLE_FREQUENCY = 8'd1;
  localparam logic [7:0] REG_WALL_THRESHOLD   = 8'd2;

  // Reset values of the configuration registers.
  localparam logic [31:0] SEED_RESET      = 32'd0;
  localparam logic [15:0] FREQUENCY_RESET = 16'd13107;
  localparam logic [15:0] THRESHOLD_RESET = 16'd32768;

  // Lattice hash multipliers.
  localparam logic [31:0] HASH_K1 = 32'd374761393;
  localparam logic [31:0] HASH_K2 = 32'd668265263;
  localparam logic [31:0] HASH_K3 = 32'd1274126177;

  // Quintic fade coefficients: 6t^5 - 15t^4 + 10t^3.
  localparam logic [20:0] FADE_C10 = 21'd655360;
  localparam logic [3:0]  FADE_C15 = 4'd15;
  localparam logic [3:0]  FADE_C6  = 4'd6;

  // Stage enables handed to the fade pipeline.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } fade_en_t;

endpackage

`default_nettype wire

>>> hw/rtl/vntc_fade.sv
// Three-stage pipelined quintic fade of a Q0.16 fraction.
`default_nettype none

module vntc_fade (
  input  wire logic              clk,
  input  wire vntc_pkg::fade_en_t en,
  input  wire logic [15:0]       frac,
  output logic [15:0]            fade
);

  logic [15:0] frac_a;
  logic [15:0] t2_a;
  logic [31:0] sq;
  logic [15:0] t3_b;
  logic [19:0] q_b;
  logic [31:0] cube;
  logic [20:0] q_sum;
  logic [35:0] prod;
  logic [19:0] r;

  // Square of the fraction.
  assign sq = frac * frac;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      frac_a <= frac;
      t2_a   <= sq[31:16];
    end
  end

  // Cube and the quadratic factor 10 - 15t + 6t^2, always positive.
  assign cube  = t2_a * frac_a;
  assign q_sum = vntc_pkg::FADE_C10 + 21'(t2_a) * 21'(vntc_pkg::FADE_C6)
                 - 21'(frac_a) * 21'(vntc_pkg::FADE_C15);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      t3_b <= cube[31:16];
      q_b  <= q_sum[19:0];
    end
  end

  // Final product, saturated to the top of the Q0.16 range.
  assign prod = t3_b * q_b;
  assign r    = prod[35:16];

  always_ff @(posedge clk) begin
    if (en.s4) begin
      fade <= (r > 20'hFFFF) ? 16'hFFFF : r[15:0];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/value_noise_tile_classifier_core.sv
// Pipeline: a result is presented from the last of six register stages, the first
// loaded at the edge that accepts its tile coordinate beat.
// Throughput: one beat per cycle while the output is not stalled, through the six
// stages (scale, hash multiply, shift-xor, final hash multiply, two interpolation
// stages); each stage moves on its own, so bubbles close up under output stall.
// Reset: synchronous rst clears all stage valid bits and loads the register
// defaults (seed 0, frequency 13107, threshold 32768).
`default_nettype none

module value_noise_tile_classifier_core #(
  parameter int COORD_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [7:0]            cfg_index,
  input  wire logic [31:0]           cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COORD_BITS-1:0] tile_x,
  input  wire logic [COORD_BITS-1:0] tile_y,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [15:0]                noise_value,
  output logic                       wall
);

  localparam int POS_BITS = COORD_BITS + 16;

  // Truncating fixed-point lerp between two 16-bit values.
  function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                        input logic [15:0] u);
    logic [15:0] d;
    logic [31:0] p;
    if (b >= a) begin
      d = b - a;
      p = d * u;
      return a + p[31:16];
    end else begin
      d = a - b;
      p = d * u;
      return a - p[31:16];
    end
  endfunction

  logic [31:0] noise_seed;
  logic [15:0] sample_frequency;
  logic [15:0] wall_threshold;

  logic [6:1] vld;
  logic [6:1] rdy;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_seed       <= vntc_pkg::SEED_RESET;
      sample_frequency <= vntc_pkg::FREQUENCY_RESET;
      wall_threshold   <= vntc_pkg::THRESHOLD_RESET;
    end else if (cfg_write) begin
      if (cfg_index == vntc_pkg::REG_NOISE_SEED) begin
        noise_seed <= cfg_data;
      end
      if (cfg_index == vntc_pkg::REG_SAMPLE_FREQUENCY) begin
        sample_frequency <= cfg_data[15:0];
      end
      if (cfg_index == vntc_pkg::REG_WALL_THRESHOLD) begin
        wall_threshold <= cfg_data[15:0];
      end
    end
  end

  // A stage loads when it is empty or the stage after it moves.
  always_comb begin
    rdy[6] = !vld[6] || !out_stall;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = vld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= in_valid;
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 1: scale the coordinates to lattice positions.
  logic [POS_BITS-1:0] px, py;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      px <= POS_BITS'(tile_x) * POS_BITS'(sample_frequency);
      py <= POS_BITS'(tile_y) * POS_BITS'(sample_frequency);
    end
  end

  // Stage 2: per-axis hash terms of the lower cell corner.
  logic [COORD_BITS-1:0] cx, cy;
  logic [31:0] hx0, hy0;

  assign cx = px[POS_BITS-1:16];
  assign cy = py[POS_BITS-1:16];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      hx0 <= 32'(cx) * vntc_pkg::HASH_K1;
      hy0 <= 32'(cy) * vntc_pkg::HASH_K2;
    end
  end

  // Fade of both fractions, in step with stages 2 to 4.
  vntc_pkg::fade_en_t fade_en;
  logic [15:0] u4, v4;

  assign fade_en.s2 = rdy[2];
  assign fade_en.s3 = rdy[3];
  assign fade_en.s4 = rdy[4];

  vntc_fade u_fade_x (
    .clk  (clk),
    .en   (fade_en),
    .frac (px[15:0]),
    .fade (u4)
  );

  vntc_fade u_fade_y (
    .clk  (clk),
    .en   (fade_en),
    .frac (py[15:0]),
    .fade (v4)
  );

  // Stage 3: seed mix and shift-xor for the four corners.
  // The next corner term is the lower one plus the multiplier.
  logic [31:0] hx1, hy1;
  logic [31:0] s00, s10, s01, s11;
  logic [15:0] t00, t10, t01, t11;

  assign hx1 = hx0 + vntc_pkg::HASH_K1;
  assign hy1 = hy0 + vntc_pkg::HASH_K2;
  assign s00 = noise_seed ^ hx0 ^ hy0;
  assign s10 = noise_seed ^ hx1 ^ hy0;
  assign s01 = noise_seed ^ hx0 ^ hy1;
  assign s11 = noise_seed ^ hx1 ^ hy1;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      t00 <= s00[15:0] ^ s00[28:13];
      t10 <= s10[15:0] ^ s10[28:13];
      t01 <= s01[15:0] ^ s01[28:13];
      t11 <= s11[15:0] ^ s11[28:13];
    end
  end

  // Stage 4: final hash multiply; only the low 16 bits are kept.
  logic [15:0] n00, n10, n01, n11;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      n00 <= 16'(t00 * vntc_pkg::HASH_K3[15:0]);
      n10 <= 16'(t10 * vntc_pkg::HASH_K3[15:0]);
      n01 <= 16'(t01 * vntc_pkg::HASH_K3[15:0]);
      n11 <= 16'(t11 * vntc_pkg::HASH_K3[15:0]);
    end
  end

  // Stage 5: blend along x for both rows.
  logic [15:0] r0, r1, v5;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      r0 <= blend(n00, n10, u4);
      r1 <= blend(n01, n11, u4);
      v5 <= v4;
    end
  end

  // Stage 6: blend along y and compare against the threshold.
  logic [15:0] n_mix;

  assign n_mix = blend(r0, r1, v5);

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      noise_value <= n_mix;
      wall        <= n_mix < wall_threshold;
    end
  end

`ifndef NO_ASSERTIONS
  // Input is held back only when every stage holds a beat.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> (&vld))
    else $error("input stalled while the pipeline has a bubble");

  // A stalled result stays valid in the next cycle.
  assert property (@(posedge clk) disable iff (rst) (vld[6] && out_stall) |=> vld[6])
    else $error("stalled result was dropped");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

>>> tb/sv/value_noise_tile_classifier_core_tb.sv
// Self-checking testbench for the value noise tile classifier core.
`timescale 1ns / 1ps

module value_noise_tile_classifier_core_tb;

  localparam int COORD_BITS = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int TILES_PER_PHASE = 110;
  localparam int MAX_REPORTS = 20;

  // Indexes outside the register map; writes to them must be dropped.
  localparam logic [7:0] REG_UNUSED_LOW  = 8'd3;
  localparam logic [7:0] REG_UNUSED_HIGH = 8'd255;

  // Lattice hash multipliers.
  localparam logic [31:0] MIX_X   = 32'd374761393;
  localparam logic [31:0] MIX_Y   = 32'd668265263;
  localparam logic [31:0] MIX_OUT = 32'd1274126177;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } tile_coord_t;

  typedef struct packed {
    logic [15:0] noise;
    logic        wall;
  } tile_class_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [7:0]            cfg_index = '0;
  logic [31:0]           cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [COORD_BITS-1:0] tile_x = '0;
  logic [COORD_BITS-1:0] tile_y = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [15:0]           noise_value;
  logic                  wall;

  // Shadow copy of the configuration registers.
  logic [31:0] seed_q   = vntc_pkg::SEED_RESET;
  logic [15:0] freq_q   = vntc_pkg::FREQUENCY_RESET;
  logic [15:0] thresh_q = vntc_pkg::THRESHOLD_RESET;

  tile_coord_t tiles_waiting[$];
  tile_class_t classes_due[$];
  int          tiles_unsent = 0;
  int          tiles_sent = 0;
  int          classes_checked = 0;
  int          walls_seen = 0;
  int          fail_count = 0;
  int          settings_count = 1;
  int          cycle_count = 0;
  int          feed_gap = 0;
  int          drain_gap = 0;
  bit          smooth_flow = 1'b0;

  value_noise_tile_classifier_core #(
    .COORD_BITS(COORD_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .tile_x(tile_x),
    .tile_y(tile_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .noise_value(noise_value),
    .wall(wall)
  );

  // 20 ns clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Hash of one lattice corner, low 16 bits kept.
  function automatic logic [15:0] lattice_hash(input logic [31:0] cx, input logic [31:0] cy);
    logic [31:0] s;
    s = seed_q ^ (cx * MIX_X) ^ (cy * MIX_Y);
    s = (s ^ (s >> 13)) * MIX_OUT;
    return s[15:0];
  endfunction

  // Quintic fade 6t^5 - 15t^4 + 10t^3 in Q0.16, saturated at the top.
  function automatic logic [15:0] quintic16(input logic [15:0] f);
    logic [63:0] ff;
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] q;
    logic [63:0] r;
    ff = 64'(f);
    t2 = (ff * ff) >> 16;
    t3 = (t2 * ff) >> 16;
    q = 64'd655360 + 64'd6 * t2 - 64'd15 * ff;
    r = (t3 * q) >> 16;
    return (r > 64'hFFFF) ? 16'hFFFF : r[15:0];
  endfunction

  // Truncating lerp that always stays between its two end points.
  function automatic logic [15:0] blend16(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] u);
    logic [31:0] span;
    if (b >= a) begin
      span = (32'(b - a) * 32'(u)) >> 16;
      return a + span[15:0];
    end
    span = (32'(a - b) * 32'(u)) >> 16;
    return a - span[15:0];
  endfunction

  // Noise value and wall bit of one tile under the current settings.
  function automatic tile_class_t classify_tile(input logic [COORD_BITS-1:0] x,
                                                input logic [COORD_BITS-1:0] y);
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [15:0] u;
    logic [15:0] v;
    logic [15:0] r0;
    logic [15:0] r1;
    tile_class_t res;
    px = 32'(x) * 32'(freq_q);
    py = 32'(y) * 32'(freq_q);
    cx = px >> 16;
    cy = py >> 16;
    u = quintic16(px[15:0]);
    v = quintic16(py[15:0]);
    r0 = blend16(lattice_hash(cx, cy), lattice_hash(cx + 32'd1, cy), u);
    r1 = blend16(lattice_hash(cx, cy + 32'd1), lattice_hash(cx + 32'd1, cy + 32'd1), u);
    res.noise = blend16(r0, r1, v);
    res.wall = (res.noise < thresh_q);
    return res;
  endfunction

  // Tile feeder: presents queued coordinates and records the expected class of
  // each accepted beat.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tile_x <= '0;
      tile_y <= '0;
      feed_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        classes_due.push_back(classify_tile(tile_x, tile_y));
        tiles_unsent--;
        tiles_sent++;
        feed_gap = smooth_flow ? 0 : $urandom_range(0, 9);
      end
      if (!in_valid || !in_stall) begin
        if (feed_gap == 0 && tiles_waiting.size() != 0) begin
          tile_coord_t c;
          c = tiles_waiting.pop_front();
          in_valid <= 1'b1;
          tile_x <= c.x;
          tile_y <= c.y;
        end else begin
          in_valid <= 1'b0;
          if (feed_gap != 0) feed_gap--;
        end
      end
    end
  end

  // Result checker with random back-pressure after each beat outside smooth phases.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      drain_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (classes_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result noise=%h wall=%b", $time, noise_value, wall);
        end else begin
          tile_class_t exp_class;
          exp_class = classes_due.pop_front();
          classes_checked++;
          if (wall) walls_seen++;
          if (noise_value !== exp_class.noise) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: noise_value expected %h, got %h", $time, exp_class.noise,
                       noise_value);
          end
          if (wall !== exp_class.wall) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: wall expected %b, got %b", $time, exp_class.wall, wall);
          end
        end
        drain_gap = smooth_flow ? 0 : $urandom_range(0, 9);
      end
      if (drain_gap != 0) begin
        out_stall <= 1'b1;
        drain_gap--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, classes_due.size());
      $display("value_noise_tile_classifier_core test failed");
      $finish;
    end
  end

  // Block until every queued tile has been classified and checked.
  task automatic wait_idle();
    while (tiles_unsent != 0 || classes_due.size() != 0) @(posedge clk);
  endtask

  // One register write beat; the caller lowers cfg_write after the last one.
  task automatic put_reg(input logic [7:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      vntc_pkg::REG_NOISE_SEED:       seed_q = data;
      vntc_pkg::REG_SAMPLE_FREQUENCY: freq_q = data[15:0];
      vntc_pkg::REG_WALL_THRESHOLD:   thresh_q = data[15:0];
      default: ;
    endcase
  endtask

  // Load a full setting; upper data bits of the narrow registers carry junk.
  task automatic set_regs(input logic [31:0] seed, input logic [15:0] freq,
                          input logic [15:0] thresh, input bit stray);
    wait_idle();
    put_reg(vntc_pkg::REG_NOISE_SEED, seed);
    put_reg(vntc_pkg::REG_SAMPLE_FREQUENCY, {16'($urandom), freq});
    put_reg(vntc_pkg::REG_WALL_THRESHOLD, {16'($urandom), thresh});
    if (stray) begin
      put_reg(REG_UNUSED_LOW, $urandom);
      put_reg(REG_UNUSED_HIGH, $urandom);
    end
    cfg_write <= 1'b0;
    settings_count++;
  endtask

  task automatic queue_tile(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
    tile_coord_t c;
    c.x = x;
    c.y = y;
    tiles_waiting.push_back(c);
    tiles_unsent++;
  endtask

  // Mostly uniform coordinates, now and then an edge of the map.
  function automatic logic [COORD_BITS-1:0] pick_coord();
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? '1 : '0;
    return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
  endfunction

  // Stimulus sequence.
  initial begin
    logic [15:0] freq;
    logic [15:0] thresh;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: corners of the map and two inner tiles.
    queue_tile('0, '0);
    queue_tile('1, '1);
    queue_tile('0, '1);
    queue_tile('1, '0);
    queue_tile(10'd1, 10'd1);
    queue_tile(10'd512, 10'd341);

    // Zero frequency: every tile lands on the origin cell.
    set_regs(32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 1'b0);
    queue_tile('0, '0);
    queue_tile('1, '1);
    queue_tile(10'd5, 10'd1000);
    queue_tile(10'd700, 10'd3);

    // Full frequency with stray index writes; x = 1 puts the fraction at its
    // top so the fade runs at the edge of its range.
    set_regs($urandom, 16'hFFFF, 16'h0000, 1'b1);
    queue_tile(10'd1, 10'd1);
    queue_tile(10'd1, '0);
    queue_tile('1, '1);
    queue_tile(10'd2, 10'd1023);
    queue_tile(10'd1022, 10'd511);
    queue_tile('0, 10'd1);

    // Tiny frequency: fractions stay in the lowest cell.
    set_regs(32'h0000_0000, 16'h0001, 16'h0001, 1'b0);
    queue_tile('1, '1);
    queue_tile(10'd512, '0);
    queue_tile(10'd3, 10'd1020);
    queue_tile(10'd77, 10'd900);

    // Random settings, each followed by a burst of random tiles.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: freq = 16'($urandom);
        1: freq = 16'($urandom_range(1, 64));
        2: freq = 16'hFFFF;
        default: freq = 16'($urandom_range(0, 4095));
      endcase
      case (p % 3)
        0: thresh = 16'($urandom);
        1: thresh = (p % 2 == 0) ? 16'h0000 : 16'hFFFF;
        default: thresh = 16'($urandom_range(16384, 49152));
      endcase
      set_regs($urandom, freq, thresh, (p % 2) == 1);
      smooth_flow = (p % 3) == 1;
      for (int i = 0; i < TILES_PER_PHASE; i++) queue_tile(pick_coord(), pick_coord());
    end

    // Drain and let the pipeline settle.
    wait_idle();
    repeat (12) @(posedge clk);
    $display("Classified %0d tiles under %0d register settings, %0d results checked,",
             tiles_sent, settings_count, classes_checked);
    $display("%0d of them walls, %0d mismatches.", walls_seen, fail_count);
    if (fail_count == 0) begin
      $display("value_noise_tile_classifier_core test passed");
    end else begin
      $display("value_noise_tile_classifier_core test failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/vntc_pkg.sv
hw/rtl/vntc_fade.sv
hw/rtl/value_noise_tile_classifier_core.sv
tb/sv/value_noise_tile_classifier_core_tb.sv
